// ===== sv/pcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// shared types, register codes and constants of the colorfulness classifier
// ----------------------------------------------------------------------------
package pcc_pkg;

  // widths fixed by the item fields
  localparam int ChanW  = 8;
  localparam int PctW   = 7;
  localparam int CountW = 11;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 11;

  localparam logic [CfgIdxW-1:0] CfgIdxAlphaMin      = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxSaturationPct = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgIdxColorfulPct   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdxMinOpaque     = 3'd3;

  localparam logic [ChanW-1:0]  AlphaMinRst      = 8'd128;
  localparam logic [PctW-1:0]   SaturationPctRst = 7'd30;
  localparam logic [PctW-1:0]   ColorfulPctRst   = 7'd15;
  localparam logic [CountW-1:0] MinOpaqueRst     = 11'd16;

  // counter limit: frame size, or the largest 11 bit value
  localparam int MaxPixels = 1024;
  localparam int CountMax  = (1 << CountW) - 1;
  localparam logic [CountW-1:0] CountCap =
      (MaxPixels < CountMax) ? CountW'(MaxPixels) : CountW'(CountMax);

  // percent scale for the division-free compares
  localparam int PctScale = 100;

  // product widths
  localparam int PixProdW   = ChanW + PctW;   // 15 bits
  localparam int FrameProdW = CountW + PctW;  // 18 bits

  typedef struct packed {
    logic [ChanW-1:0]  alpha_min;
    logic [PctW-1:0]   saturation_pct;
    logic [PctW-1:0]   colorful_pct;
    logic [CountW-1:0] min_opaque;
  } cfg_t;

  // classified pixel between the pixel stage and the counters
  typedef struct packed {
    logic valid;
    logic opaque;
    logic saturated;
    logic last;
  } flags_t;

  // closed frame between the counters and the verdict stage
  typedef struct packed {
    logic              valid;
    logic [CountW-1:0] opaque_total;
    logic [CountW-1:0] saturated_total;
  } frame_t;

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] c);
    bump = (c < CountCap) ? c + CountW'(1) : CountCap;
  endfunction

endpackage

// ===== sv/pixel_colorfulness_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_colorfulness_classifier_core
// streaming RGBA classifier that judges whether a frame is multicolored
// ----------------------------------------------------------------------------
// usage
//   pixel items enter on in_valid_i / in_ready_o, one RGBA pixel each, with
//   last_pixel_i marking the final pixel of a frame
//   only a frame's last pixel yields a result item, on out_valid_o /
//   out_ready_i; ordinary pixels only update the frame counters
//   thresholds sit in four registers written on cfg_valid_i / cfg_ready_o
//   (index 0 alpha_min, 1 saturation_pct, 2 colorful_pct, 3 min_opaque);
//   the port is always ready, other indexes are dropped; write while idle
//   throughput is one pixel per cycle while nothing stalls; the result of a
//   last pixel passes the input register, flag register, frame register
//   and result register in turn
//   when the receiver stalls, the result register holds, the next closed
//   frame waits in the frame register and pixels keep flowing until a
//   further frame end reaches the flag register; then the stall backs up
//   to in_ready_o
//   reset (a change of observed target) clears counters, verdict flags and
//   pipeline valids, and restores the register defaults; no clearing pass
// ----------------------------------------------------------------------------
module pixel_colorfulness_classifier_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [pcc_pkg::ChanW-1:0]     red_i,
  input  logic [pcc_pkg::ChanW-1:0]     green_i,
  input  logic [pcc_pkg::ChanW-1:0]     blue_i,
  input  logic [pcc_pkg::ChanW-1:0]     alpha_i,
  input  logic                          last_pixel_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          verdict_known_o,
  output logic                          is_colorful_o,
  output logic                          result_changed_o,
  output logic                          frame_trusted_o,
  output logic [pcc_pkg::CountW-1:0]    opaque_total_o,
  output logic [pcc_pkg::CountW-1:0]    saturated_total_o,
  // configuration channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pcc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pcc_pkg::*;

  cfg_t   cfg;          // current thresholds
  flags_t flags;        // classified pixel
  frame_t frame;        // closed frame totals
  logic   flags_take;   // counters consume the classified pixel
  logic   frame_take;   // verdict stage consumes the closed frame

  pcc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // opaque test and division-free saturation test per pixel
  pcc_pixel_stage u_pixel_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .alpha_i      (alpha_i),
    .last_pixel_i (last_pixel_i),
    .cfg_i        (cfg),
    .flags_take_i (flags_take),
    .flags_o      (flags)
  );

  // saturating counts, cleared as each frame closes
  pcc_frame_counter u_frame_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .flags_i      (flags),
    .flags_take_o (flags_take),
    .frame_take_i (frame_take),
    .frame_o      (frame)
  );

  // trust check, colorful share, sticky verdict and change flag
  pcc_verdict u_verdict (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .frame_i           (frame),
    .frame_take_o      (frame_take),
    .cfg_i             (cfg),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .verdict_known_o   (verdict_known_o),
    .is_colorful_o     (is_colorful_o),
    .result_changed_o  (result_changed_o),
    .frame_trusted_o   (frame_trusted_o),
    .opaque_total_o    (opaque_total_o),
    .saturated_total_o (saturated_total_o)
  );

endmodule

// ===== sv/pcc_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_cfg_regs
// threshold registers written through the configuration channel
// ----------------------------------------------------------------------------
module pcc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pcc_pkg::CfgDataW-1:0]  cfg_data_i,
  output pcc_pkg::cfg_t                 cfg_o
);
  import pcc_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_min      <= AlphaMinRst;
      cfg_q.saturation_pct <= SaturationPctRst;
      cfg_q.colorful_pct   <= ColorfulPctRst;
      cfg_q.min_opaque     <= MinOpaqueRst;
    end else if (wr_en) begin
      case (cfg_index_i)
        CfgIdxAlphaMin:      cfg_q.alpha_min      <= cfg_data_i[ChanW-1:0];
        CfgIdxSaturationPct: cfg_q.saturation_pct <= cfg_data_i[PctW-1:0];
        CfgIdxColorfulPct:   cfg_q.colorful_pct   <= cfg_data_i[PctW-1:0];
        CfgIdxMinOpaque:     cfg_q.min_opaque     <= cfg_data_i[CountW-1:0];
        default: ;  // unknown index, ignored
      endcase
    end
  end

endmodule

// ===== sv/pcc_pixel_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pixel_stage
// input register and per-pixel opaque / saturated classification
// ----------------------------------------------------------------------------
module pcc_pixel_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [pcc_pkg::ChanW-1:0]   red_i,
  input  logic [pcc_pkg::ChanW-1:0]   green_i,
  input  logic [pcc_pkg::ChanW-1:0]   blue_i,
  input  logic [pcc_pkg::ChanW-1:0]   alpha_i,
  input  logic                        last_pixel_i,
  input  pcc_pkg::cfg_t               cfg_i,
  input  logic                        flags_take_i,
  output pcc_pkg::flags_t             flags_o
);
  import pcc_pkg::*;

  logic             s1_valid_q;
  logic [ChanW-1:0] red_q, green_q, blue_q, alpha_q;
  logic             last_q;
  flags_t           flags_q;

  logic             s2_free, s1_free, s1_load, s2_load;
  logic [ChanW-1:0] hi, lo;
  logic [PixProdW-1:0] spread_scaled, hi_scaled;
  logic             opaque, saturated;

  assign s2_free    = !flags_q.valid || flags_take_i;
  assign s1_free    = !s1_valid_q || s2_free;
  assign in_ready_o = s1_free;
  assign s1_load    = in_valid_i && s1_free;
  assign s2_load    = s1_valid_q && s2_free;

  // max / min of the three channels
  always_comb begin
    hi = red_q;
    lo = red_q;
    if (green_q > hi) hi = green_q;
    if (blue_q  > hi) hi = blue_q;
    if (green_q < lo) lo = green_q;
    if (blue_q  < lo) lo = blue_q;
  end

  // (max - min) * 100 > pct * max
  assign spread_scaled = PixProdW'(hi - lo) * PixProdW'(PctScale);
  assign hi_scaled     = PixProdW'(cfg_i.saturation_pct) * PixProdW'(hi);
  assign opaque        = alpha_q >= cfg_i.alpha_min;
  assign saturated     = opaque && (spread_scaled > hi_scaled);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      flags_q    <= '0;
    end else begin
      if (s1_free) s1_valid_q <= in_valid_i;
      if (s2_free) flags_q.valid <= s1_valid_q;
      if (s2_load) begin
        flags_q.opaque    <= opaque;
        flags_q.saturated <= saturated;
        flags_q.last      <= last_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      alpha_q <= alpha_i;
      last_q  <= last_pixel_i;
    end
  end

  assign flags_o = flags_q;

endmodule

// ===== sv/pcc_frame_counter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_frame_counter
// saturating per-frame counters, closed into a frame register on the last pixel
// ----------------------------------------------------------------------------
module pcc_frame_counter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pcc_pkg::flags_t  flags_i,
  output logic             flags_take_o,
  input  logic             frame_take_i,
  output pcc_pkg::frame_t  frame_o
);
  import pcc_pkg::*;

  logic [CountW-1:0] opaque_cnt_q, saturated_cnt_q;
  logic [CountW-1:0] opaque_cnt_d, saturated_cnt_d;
  frame_t            frame_q;
  logic              frame_free, take, close;

  assign frame_free   = !frame_q.valid || frame_take_i;
  // ordinary pixels never wait, a frame end waits for a free frame register
  assign take         = flags_i.valid && (!flags_i.last || frame_free);
  assign close        = take && flags_i.last;
  assign flags_take_o = take;

  assign opaque_cnt_d    = flags_i.opaque    ? bump(opaque_cnt_q)    : opaque_cnt_q;
  assign saturated_cnt_d = flags_i.saturated ? bump(saturated_cnt_q) : saturated_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opaque_cnt_q    <= '0;
      saturated_cnt_q <= '0;
      frame_q         <= '0;
    end else begin
      if (take) begin
        opaque_cnt_q    <= flags_i.last ? '0 : opaque_cnt_d;
        saturated_cnt_q <= flags_i.last ? '0 : saturated_cnt_d;
      end
      if (frame_free) frame_q.valid <= close;
      if (close) begin
        frame_q.opaque_total    <= opaque_cnt_d;
        frame_q.saturated_total <= saturated_cnt_d;
      end
    end
  end

  assign frame_o = frame_q;

endmodule

// ===== sv/pcc_verdict.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_verdict
// frame judgement, verdict flags and the result register
// ----------------------------------------------------------------------------
module pcc_verdict (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pcc_pkg::frame_t             frame_i,
  output logic                        frame_take_o,
  input  pcc_pkg::cfg_t               cfg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        verdict_known_o,
  output logic                        is_colorful_o,
  output logic                        result_changed_o,
  output logic                        frame_trusted_o,
  output logic [pcc_pkg::CountW-1:0]  opaque_total_o,
  output logic [pcc_pkg::CountW-1:0]  saturated_total_o
);
  import pcc_pkg::*;

  logic                  known_q, colorful_q, out_valid_q;
  logic                  known_d, colorful_d;
  logic                  changed_q, trusted_q;
  logic [CountW-1:0]     opaque_q, saturated_q;
  logic                  out_free, take;
  logic                  trusted, colorful, changed;
  logic [FrameProdW-1:0] sat_scaled, opq_scaled;

  assign out_free     = !out_valid_q || out_ready_i;
  assign take         = frame_i.valid && out_free;
  assign frame_take_o = take;

  // saturated * 100 > pct * opaque
  assign sat_scaled = FrameProdW'(frame_i.saturated_total) * FrameProdW'(PctScale);
  assign opq_scaled = FrameProdW'(cfg_i.colorful_pct) * FrameProdW'(frame_i.opaque_total);
  assign trusted    = frame_i.opaque_total >= cfg_i.min_opaque;
  assign colorful   = sat_scaled > opq_scaled;
  assign changed    = trusted && (!known_q || (colorful != colorful_q));
  assign known_d    = known_q || trusted;
  assign colorful_d = trusted ? colorful : colorful_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q     <= 1'b0;
      colorful_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        known_q    <= known_d;
        colorful_q <= colorful_d;
      end
      if (out_free) out_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      changed_q   <= changed;
      trusted_q   <= trusted;
      opaque_q    <= frame_i.opaque_total;
      saturated_q <= frame_i.saturated_total;
    end
  end

  // the flag registers already hold the post-update verdict
  assign out_valid_o       = out_valid_q;
  assign verdict_known_o   = known_q;
  assign is_colorful_o     = colorful_q;
  assign result_changed_o  = changed_q;
  assign frame_trusted_o   = trusted_q;
  assign opaque_total_o    = opaque_q;
  assign saturated_total_o = saturated_q;

endmodule

// ===== tb/pcc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_checker
// predicts the frame verdict of the colorfulness classifier and checks each
// result item against it
// ----------------------------------------------------------------------------
module pcc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic [pcc_pkg::ChanW-1:0]     red_i,
  input  logic [pcc_pkg::ChanW-1:0]     green_i,
  input  logic [pcc_pkg::ChanW-1:0]     blue_i,
  input  logic [pcc_pkg::ChanW-1:0]     alpha_i,
  input  logic                          last_pixel_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          verdict_known_i,
  input  logic                          is_colorful_i,
  input  logic                          result_changed_i,
  input  logic                          frame_trusted_i,
  input  logic [pcc_pkg::CountW-1:0]    opaque_total_i,
  input  logic [pcc_pkg::CountW-1:0]    saturated_total_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [pcc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pcc_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            fail_count_o,
  output int                            frames_pending_o,
  output int                            pixels_seen_o,
  output int                            frames_checked_o,
  output int                            trusted_seen_o,
  output int                            colorful_seen_o
);

  typedef struct packed {
    logic                       known;
    logic                       colorful;
    logic                       changed;
    logic                       trusted;
    logic [pcc_pkg::CountW-1:0] opaque;
    logic [pcc_pkg::CountW-1:0] saturated;
  } verdict_t;

  pcc_pkg::cfg_t              thresholds;
  logic [pcc_pkg::CountW-1:0] opaque_cnt;
  logic [pcc_pkg::CountW-1:0] saturated_cnt;
  logic                       known_flag;
  logic                       colorful_flag;
  verdict_t                   verdict_q[$];

  task automatic compare_field(input string name, input logic [pcc_pkg::CountW-1:0] want,
                               input logic [pcc_pkg::CountW-1:0] got);
    if (got !== want) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // classify one pixel, and on a frame end judge the frame
  task automatic judge_pixel(input logic [pcc_pkg::ChanW-1:0] r, g, b, a, input logic last);
    int       hi;
    int       lo;
    logic     col;
    verdict_t v;
    if (a >= thresholds.alpha_min) begin
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      if (opaque_cnt != pcc_pkg::CountCap) opaque_cnt++;
      if ((hi - lo) * pcc_pkg::PctScale > int'(thresholds.saturation_pct) * hi)
        if (saturated_cnt != pcc_pkg::CountCap) saturated_cnt++;
    end
    if (last) begin
      v.trusted = (opaque_cnt >= thresholds.min_opaque);
      v.changed = 1'b0;
      if (v.trusted) begin
        col = (int'(saturated_cnt) * pcc_pkg::PctScale >
               int'(thresholds.colorful_pct) * int'(opaque_cnt));
        v.changed     = !known_flag || (col != colorful_flag);
        known_flag    = 1'b1;
        colorful_flag = col;
      end
      v.known     = known_flag;
      v.colorful  = colorful_flag;
      v.opaque    = opaque_cnt;
      v.saturated = saturated_cnt;
      verdict_q.push_back(v);
      opaque_cnt    = '0;
      saturated_cnt = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      thresholds.alpha_min      = pcc_pkg::AlphaMinRst;
      thresholds.saturation_pct = pcc_pkg::SaturationPctRst;
      thresholds.colorful_pct   = pcc_pkg::ColorfulPctRst;
      thresholds.min_opaque     = pcc_pkg::MinOpaqueRst;
      opaque_cnt       = '0;
      saturated_cnt    = '0;
      known_flag       = 1'b0;
      colorful_flag    = 1'b0;
      verdict_q.delete();
      fail_count_o     = 0;
      pixels_seen_o    = 0;
      frames_checked_o = 0;
      trusted_seen_o   = 0;
      colorful_seen_o  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result item with no frame end pending, expected none actual %0d/%0d",
                   $time, opaque_total_i, saturated_total_i);
        end else begin
          want = verdict_q.pop_front();
          compare_field("verdict_known", want.known, verdict_known_i);
          compare_field("is_colorful", want.colorful, is_colorful_i);
          compare_field("result_changed", want.changed, result_changed_i);
          compare_field("frame_trusted", want.trusted, frame_trusted_i);
          compare_field("opaque_total", want.opaque, opaque_total_i);
          compare_field("saturated_total", want.saturated, saturated_total_i);
          frames_checked_o++;
          if (want.trusted) trusted_seen_o++;
          if (want.trusted && want.colorful) colorful_seen_o++;
        end
      end
      // writes to indexes past the register list are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pcc_pkg::CfgIdxAlphaMin:
            thresholds.alpha_min = cfg_data_i[pcc_pkg::ChanW-1:0];
          pcc_pkg::CfgIdxSaturationPct:
            thresholds.saturation_pct = cfg_data_i[pcc_pkg::PctW-1:0];
          pcc_pkg::CfgIdxColorfulPct:
            thresholds.colorful_pct = cfg_data_i[pcc_pkg::PctW-1:0];
          pcc_pkg::CfgIdxMinOpaque:
            thresholds.min_opaque = cfg_data_i[pcc_pkg::CountW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        pixels_seen_o++;
        judge_pixel(red_i, green_i, blue_i, alpha_i, last_pixel_i);
      end
    end
    frames_pending_o = verdict_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives pixel frames and threshold settings into the colorfulness
// classifier; a side checker predicts every frame verdict and compares
// ----------------------------------------------------------------------------
module testbench;

  localparam int HalfPeriod    = 4;
  localparam int WatchdogLimit = 4000;
  // after the last verdict, leave margin before idle-only actions
  localparam int SettleCycles  = 8;
  localparam int RandomPixels  = 245;
  localparam int RandomPhases  = 7;
  localparam int CapFrameLen   = 1040;

  // an index past the four registers, must be dropped by the block
  localparam logic [pcc_pkg::CfgIdxW-1:0] CfgIdxUnused = 3'd5;

  typedef enum int {PixVivid, PixGray, PixBlack, PixEdge, PixNoise} pix_kind_e;

  typedef struct packed {
    logic [pcc_pkg::ChanW-1:0] r;
    logic [pcc_pkg::ChanW-1:0] g;
    logic [pcc_pkg::ChanW-1:0] b;
    logic [pcc_pkg::ChanW-1:0] a;
  } rgba_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // pixel channel
  logic                          in_valid   = 1'b0;
  logic                          in_ready;
  logic [pcc_pkg::ChanW-1:0]     red        = '0;
  logic [pcc_pkg::ChanW-1:0]     green      = '0;
  logic [pcc_pkg::ChanW-1:0]     blue       = '0;
  logic [pcc_pkg::ChanW-1:0]     alpha      = '0;
  logic                          last_pixel = 1'b0;

  // result channel
  logic                          out_valid;
  logic                          out_ready  = 1'b0;
  logic                          verdict_known;
  logic                          is_colorful;
  logic                          result_changed;
  logic                          frame_trusted;
  logic [pcc_pkg::CountW-1:0]    opaque_total;
  logic [pcc_pkg::CountW-1:0]    saturated_total;

  // configuration channel
  logic                          cfg_valid  = 1'b0;
  logic                          cfg_ready;
  logic [pcc_pkg::CfgIdxW-1:0]   cfg_index  = '0;
  logic [pcc_pkg::CfgDataW-1:0]  cfg_data   = '0;

  // checker results
  int fail_count;
  int frames_in_flight;
  int pixels_seen;
  int frames_checked;
  int trusted_seen;
  int colorful_seen;

  // stimulus-side copy of the thresholds that shape the pixel mix
  logic [pcc_pkg::ChanW-1:0] cur_alpha_min = pcc_pkg::AlphaMinRst;
  int                        cur_sat_pct   = pcc_pkg::SaturationPctRst;

  int burst_left   = 1;
  int rx_hold      = 0;
  int idle_cycles  = 0;
  int settings_run = 0;

  pixel_colorfulness_classifier_core u_top (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .alpha_i           (alpha),
    .last_pixel_i      (last_pixel),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .verdict_known_o   (verdict_known),
    .is_colorful_o     (is_colorful),
    .result_changed_o  (result_changed),
    .frame_trusted_o   (frame_trusted),
    .opaque_total_o    (opaque_total),
    .saturated_total_o (saturated_total),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  pcc_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .red_i             (red),
    .green_i           (green),
    .blue_i            (blue),
    .alpha_i           (alpha),
    .last_pixel_i      (last_pixel),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .verdict_known_i   (verdict_known),
    .is_colorful_i     (is_colorful),
    .result_changed_i  (result_changed),
    .frame_trusted_i   (frame_trusted),
    .opaque_total_i    (opaque_total),
    .saturated_total_i (saturated_total),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .frames_pending_o  (frames_in_flight),
    .pixels_seen_o     (pixels_seen),
    .frames_checked_o  (frames_checked),
    .trusted_seen_o    (trusted_seen),
    .colorful_seen_o   (colorful_seen)
  );

  always #(HalfPeriod) clk = ~clk;

  // receiver: runs of stalls, long ready stretches, and coin-flip cycles
  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          out_ready <= 1'b0;
          rx_hold   <= $urandom_range(1, 12);
        end
        3: begin
          out_ready <= 1'b1;
          rx_hold   <= $urandom_range(20, 80);
        end
        default: begin
          out_ready <= 1'($urandom_range(0, 1));
          rx_hold   <= 0;
        end
      endcase
    end
  end

  // watchdog: any accepted item on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // sender gaps: bursts of random length, occasionally long unbroken runs
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic push_pixel(input logic [pcc_pkg::ChanW-1:0] r, g, b, a, input logic last);
    @(negedge clk);
    in_valid   <= 1'b1;
    red        <= r;
    green      <= g;
    blue       <= b;
    alpha      <= a;
    last_pixel <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      hold_off(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
    end
  endtask

  // wait until every verdict is back and the pipeline has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frames_in_flight != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [pcc_pkg::CfgIdxW-1:0] idx,
                           input logic [pcc_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      pcc_pkg::CfgIdxAlphaMin:      cur_alpha_min = data[pcc_pkg::ChanW-1:0];
      pcc_pkg::CfgIdxSaturationPct: cur_sat_pct = int'(data[pcc_pkg::PctW-1:0]);
      default: ;
    endcase
  endtask

  // full register set, with a stray write to an unused index first
  task automatic apply_setting(input int amin, input int spct, input int cpct, input int mopq);
    write_reg(CfgIdxUnused, pcc_pkg::CfgDataW'($urandom));
    write_reg(pcc_pkg::CfgIdxAlphaMin,
              {3'($urandom_range(0, 7)), pcc_pkg::ChanW'(amin)});
    write_reg(pcc_pkg::CfgIdxSaturationPct, pcc_pkg::CfgDataW'(spct));
    write_reg(pcc_pkg::CfgIdxColorfulPct, pcc_pkg::CfgDataW'(cpct));
    write_reg(pcc_pkg::CfgIdxMinOpaque, pcc_pkg::CfgDataW'(mopq));
    settings_run++;
  endtask

  // one pixel; vivid_pct sets the share of strongly colored pixels
  function automatic rgba_t make_pixel(input int vivid_pct);
    pix_kind_e kind;
    int        hi;
    int        lo;
    int        mid;
    int        rot;
    rgba_t     px;
    kind = ($urandom_range(0, 99) < vivid_pct) ? PixVivid : pix_kind_e'($urandom_range(1, 4));
    case (kind)
      PixVivid: begin
        hi  = $urandom_range(128, 255);
        lo  = $urandom_range(0, hi / 4);
        mid = $urandom_range(lo, hi);
      end
      PixGray: begin
        hi  = $urandom_range(0, 255);
        lo  = hi;
        mid = hi;
      end
      PixBlack: begin
        hi  = 0;
        lo  = 0;
        mid = 0;
      end
      // saturation right at the threshold, one step either side
      PixEdge: begin
        hi = $urandom_range(1, 255);
        lo = hi - (cur_sat_pct * hi) / 100 + $urandom_range(0, 2) - 1;
        if (lo < 0) lo = 0;
        if (lo > hi) lo = hi;
        mid = $urandom_range(lo, hi);
      end
      default: begin
        hi  = $urandom_range(0, 255);
        lo  = $urandom_range(0, 255);
        mid = $urandom_range(0, 255);
      end
    endcase
    rot = $urandom_range(0, 2);
    px.r = pcc_pkg::ChanW'((rot == 0) ? hi : (rot == 1) ? lo : mid);
    px.g = pcc_pkg::ChanW'((rot == 0) ? lo : (rot == 1) ? mid : hi);
    px.b = pcc_pkg::ChanW'((rot == 0) ? mid : (rot == 1) ? hi : lo);
    // alpha leans on the opacity threshold and the two ends
    case ($urandom_range(0, 5))
      0:       px.a = cur_alpha_min;
      1:       px.a = cur_alpha_min - 1'b1;
      2:       px.a = '1;
      3:       px.a = '0;
      default: px.a = pcc_pkg::ChanW'($urandom_range(0, 255));
    endcase
    return px;
  endfunction

  task automatic send_frame(input int len, input int vivid_pct);
    rgba_t px;
    for (int i = 0; i < len; i++) begin
      px = make_pixel(vivid_pct);
      push_pixel(px.r, px.g, px.b, px.a, i == len - 1);
    end
  endtask

  // frames of mixed length; many tiny ones so frame ends pile up under stalls
  task automatic random_frames(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(0, 9))
        0, 1, 2: len = $urandom_range(1, 3);
        9:       len = $urandom_range(30, 70);
        default: len = $urandom_range(4, 24);
      endcase
      send_frame(len, $urandom_range(0, 4) * 25);
      sent += len;
    end
    settle();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset thresholds: black, white, pure red, saturation exactly at 30%
    // with alpha exactly at the minimum, one alpha step short; too few
    // opaque pixels, so the frame is not trusted
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    push_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd100, 8'd70, 8'd85, 8'd128, 1'b0);
    push_pixel(8'd0, 8'd0, 8'd255, 8'd127, 1'b0);
    push_pixel(8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
    settle();

    // zero minimum: an empty frame is trusted, not colorful, verdict becomes known
    write_reg(pcc_pkg::CfgIdxMinOpaque, pcc_pkg::CfgDataW'(0));
    push_pixel(8'd10, 8'd200, 8'd30, 8'd0, 1'b1);
    settle();

    // small frames: colorful flip, hold with a just-saturated pixel, flip back
    write_reg(pcc_pkg::CfgIdxMinOpaque, pcc_pkg::CfgDataW'(2));
    push_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd200, 8'd0, 8'd10, 8'd255, 1'b1);
    push_pixel(8'd100, 8'd69, 8'd85, 8'd255, 1'b0);
    push_pixel(8'd128, 8'd128, 8'd128, 8'd255, 1'b1);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd1, 8'd1, 8'd1, 8'd255, 1'b1);
    push_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b0);
    push_pixel(8'd1, 8'd1, 8'd1, 8'd255, 1'b1);
    settle();

    // random frames under a spread of settings, extremes included
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0: apply_setting(128, 30, 15, 16);
        1: apply_setting(0, 0, 0, 0);
        2: apply_setting(255, 100, 100, 1);
        3: apply_setting(255, 127, 127, 2047);
        4: apply_setting(1, 50, 50, 4);
        5: apply_setting($urandom_range(0, 255), $urandom_range(0, 127),
                         $urandom_range(0, 127), $urandom_range(0, 12));
        default: apply_setting($urandom_range(0, 255), $urandom_range(0, 100),
                               $urandom_range(0, 100), $urandom_range(0, 3));
      endcase
      random_frames(RandomPixels / RandomPhases);
    end

    // one long all-opaque, all-saturated frame: both counters stop at the
    // cap and the minimum is met exactly there
    apply_setting(0, 0, 50, int'(pcc_pkg::CountCap));
    send_frame(CapFrameLen, 100);
    settle();

    $display("%0d pixels in %0d frames checked, %0d trusted verdicts, %0d colorful",
             pixels_seen, frames_checked, trusted_seen, colorful_seen);
    $display("%0d register settings incl. extremes, stray index writes and the counter cap",
             settings_run);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
